FILE: design/cwr_pkg.sv
// ----------------------------------------------------------------------------
// cwr_pkg: shared types and constants
// Result kinds, commands, sequencer states and the result record used by the
// chunk window receiver.
// ----------------------------------------------------------------------------
package cwr_pkg;

  // Free slot / unknown end marker
  localparam logic [31:0] FREE_MARK = 32'hffff_ffff;

  // Register reset values
  localparam logic [15:0] CHUNK_LENGTH_RST  = 16'd4096;
  localparam logic [31:0] RESEND_PERIOD_RST = 32'd3000;
  localparam logic [4:0]  WINDOW_SLOTS_RST  = 5'd16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CHUNK_LENGTH  = 2'd0,
    REG_RESEND_PERIOD = 2'd1,
    REG_WINDOW_SLOTS  = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_RESPONSE = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_REQUEST  = 3'd0,
    K_WRITE    = 3'd1,
    K_ACCEPTED = 3'd2,
    K_REJECTED = 3'd3,
    K_DONE     = 3'd4,
    K_FAILED   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_SCAN,
    S_EMIT_MUL,
    S_FIND,
    S_CHECK,
    S_DRAIN_FIND,
    S_DRAIN_ACT,
    S_DRAIN_REFILL,
    S_POST,
    S_DONE_SCAN,
    S_PAST_END,
    S_STATUS,
    S_FLUSH
  } state_t;

  typedef struct packed {
    kind_t        kind;
    logic [31:0]  chunk_index;
    logic [15:0]  byte_count;
    logic [63:0]  byte_offset;
    logic [31:0]  requests_sent;
    logic [31:0]  replies_seen;
  } res_t;

endpackage

FILE: design/cwr_if.sv
// ----------------------------------------------------------------------------
// cwr_if: request and result channels
// Valid/ready channels carrying one input request and one result.
// ----------------------------------------------------------------------------
interface cwr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic [31:0] reply_index;
  logic [15:0] reply_length;
  logic        reply_ok;
  logic        reply_is_end;
  logic        frame_ok;

  modport source (output valid, command, now_ms, reply_index, reply_length,
                  reply_ok, reply_is_end, frame_ok, input ready);
  modport sink (input valid, command, now_ms, reply_index, reply_length,
                reply_ok, reply_is_end, frame_ok, output ready);
endinterface

interface cwr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] chunk_index;
  logic [15:0] byte_count;
  logic [63:0] byte_offset;
  logic [31:0] requests_sent;
  logic [31:0] replies_seen;
  logic        last_of_run;

  modport source (output valid, kind, chunk_index, byte_count, byte_offset,
                  requests_sent, replies_seen, last_of_run, input ready);
  modport sink (input valid, kind, chunk_index, byte_count, byte_offset,
                requests_sent, replies_seen, last_of_run, output ready);
endinterface

FILE: design/cwr_out_stage.sv
// ----------------------------------------------------------------------------
// cwr_out_stage: result holding and output register
// Holds the newest result until the next one or the end of the run shows
// whether it is the last, and drives the output register.
// ----------------------------------------------------------------------------
module cwr_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cwr_pkg::res_t push_res,
  input  logic          flush,
  output logic          can_push,
  output logic          out_valid,
  input  logic          out_ready,
  output cwr_pkg::res_t out_res,
  output logic          out_last
);

  logic          pend_valid_r, pend_valid_nxt;
  cwr_pkg::res_t pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  cwr_pkg::res_t out_r, out_nxt;
  logic          last_r, last_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || out_ready;
  assign can_push = !pend_valid_r || out_free;

  // Move the held result out when a newer one arrives or the run ends
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    last_nxt       = last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (push && can_push) begin
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        last_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = push_res;
      pend_valid_nxt = 1'b1;
    end else if (flush && can_push && pend_valid_r) begin
      out_nxt        = pend_r;
      last_nxt       = 1'b1;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_last  = last_r;

endmodule

FILE: design/chunk_window_receiver_top.sv
// ----------------------------------------------------------------------------
// chunk_window_receiver_top: selective-repeat receive window
// Tracks outstanding file chunks in window slots, issues chunk requests,
// checks responses and releases chunks in order.
// ----------------------------------------------------------------------------
// Start, no-op and inactive requests are handled when accepted and emit no
// result. A tick scans the slots and issues a request for each new or stale
// chunk. A response finds and checks its slot, releases received chunks in
// order, scans for completion and reports status; the input is not ready until
// the run ends, and sink stalls delay it. A result is held while the sink is not
// ready. Synchronous reset resets the slot, transfer and sequencer state.
module chunk_window_receiver_top #(
  parameter int WINDOW        = 16,
  parameter int MAX_CHUNK_LEN = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  cwr_in_if.sink      in_ch,
  cwr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_CHUNK_LEN);
  localparam logic [6:0]  WIN7    = 7'(WINDOW);

  // Configuration
  logic [15:0] chunk_length_r;
  logic [31:0] resend_period_r;
  logic [4:0]  window_slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_length_r  <= cwr_pkg::CHUNK_LENGTH_RST;
      resend_period_r <= cwr_pkg::RESEND_PERIOD_RST;
      window_slots_r  <= cwr_pkg::WINDOW_SLOTS_RST;
    end else if (cfg_we) begin
      unique case (cwr_pkg::reg_idx_t'(cfg_index))
        cwr_pkg::REG_CHUNK_LENGTH:  chunk_length_r  <= cfg_wdata[15:0];
        cwr_pkg::REG_RESEND_PERIOD: resend_period_r <= cfg_wdata;
        cwr_pkg::REG_WINDOW_SLOTS:  window_slots_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Effective chunk length and slot count
  logic [15:0]   eff_len;
  logic [6:0]    ws_w;
  logic [CW-1:0] ws;
  logic [15:0]   rst_len;

  assign eff_len = (chunk_length_r > MAX_LEN) ? MAX_LEN : chunk_length_r;
  assign rst_len = (cwr_pkg::CHUNK_LENGTH_RST > MAX_LEN) ? MAX_LEN
                                                         : cwr_pkg::CHUNK_LENGTH_RST;
  always_comb begin
    ws_w = (window_slots_r == 5'd0) ? 7'd1 : {2'b00, window_slots_r};
    if (ws_w > WIN7) begin
      ws_w = WIN7;
    end
    ws = ws_w[CW-1:0];
  end

  // Slot state
  logic [31:0] slot_chunk_r   [WINDOW], slot_chunk_nxt   [WINDOW];
  logic        slot_req_r     [WINDOW], slot_req_nxt     [WINDOW];
  logic [31:0] slot_sent_r    [WINDOW], slot_sent_nxt    [WINDOW];
  logic [15:0] slot_exp_r     [WINDOW], slot_exp_nxt     [WINDOW];
  logic [15:0] slot_rlen_r    [WINDOW], slot_rlen_nxt    [WINDOW];
  logic        slot_rcv_r     [WINDOW], slot_rcv_nxt     [WINDOW];

  // Transfer state
  logic [31:0] next_write_r, next_write_nxt;
  logic [31:0] next_issue_r, next_issue_nxt;
  logic [31:0] end_chunk_r, end_chunk_nxt;
  logic [31:0] sent_total_r, sent_total_nxt;
  logic [31:0] recv_total_r, recv_total_nxt;
  logic        active_r, active_nxt;

  // Sequencer
  cwr_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  cwr_pkg::kind_t  kind_r, kind_nxt;
  logic            any_r, any_nxt;

  // Latched request fields
  logic [31:0] now_r, now_nxt;
  logic [31:0] rindex_r, rindex_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic        rend_r, rend_nxt;

  // Shared multiplier operands
  logic [31:0] op_chunk_r, op_chunk_nxt;
  logic [15:0] op_cnt_r, op_cnt_nxt;
  logic [15:0] op_mul_r, op_mul_nxt;
  logic [47:0] product;

  assign product = op_chunk_r * op_mul_r;

  // Result path
  logic          push, flush, can_push;
  cwr_pkg::res_t push_res, out_res;
  logic          out_last;

  logic [IW-1:0] cur;
  logic          in_ready;
  logic          accept;
  logic          at_end;

  assign cur    = idx_r[IW-1:0];
  assign at_end = (idx_r == ws);
  assign in_ready = (state_r == cwr_pkg::S_IDLE);
  assign accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      slot_chunk_nxt[j] = slot_chunk_r[j];
      slot_req_nxt[j]   = slot_req_r[j];
      slot_sent_nxt[j]  = slot_sent_r[j];
      slot_exp_nxt[j]   = slot_exp_r[j];
      slot_rlen_nxt[j]  = slot_rlen_r[j];
      slot_rcv_nxt[j]   = slot_rcv_r[j];
    end
    next_write_nxt = next_write_r;
    next_issue_nxt = next_issue_r;
    end_chunk_nxt  = end_chunk_r;
    sent_total_nxt = sent_total_r;
    recv_total_nxt = recv_total_r;
    active_nxt     = active_r;
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    kind_nxt       = kind_r;
    any_nxt        = any_r;
    now_nxt        = now_r;
    rindex_nxt     = rindex_r;
    rlen_nxt       = rlen_r;
    rend_nxt       = rend_r;
    op_chunk_nxt   = op_chunk_r;
    op_cnt_nxt     = op_cnt_r;
    op_mul_nxt     = op_mul_r;
    push           = 1'b0;
    flush          = 1'b0;
    push_res       = '0;

    unique case (state_r)
      cwr_pkg::S_IDLE: begin
        if (accept) begin
          any_nxt    = 1'b0;
          idx_nxt    = '0;
          now_nxt    = in_ch.now_ms;
          rindex_nxt = in_ch.reply_index;
          rlen_nxt   = in_ch.reply_length;
          rend_nxt   = in_ch.reply_is_end;
          if (cwr_pkg::cmd_t'(in_ch.command) == cwr_pkg::CMD_START) begin
            // Restart: load chunks 0..ws-1, free the rest
            for (int j = 0; j < WINDOW; j++) begin
              slot_chunk_nxt[j] = (j < int'(ws)) ? 32'(j) : cwr_pkg::FREE_MARK;
              slot_req_nxt[j]   = 1'b0;
              slot_sent_nxt[j]  = '0;
              slot_exp_nxt[j]   = eff_len;
              slot_rlen_nxt[j]  = '0;
              slot_rcv_nxt[j]   = 1'b0;
            end
            next_write_nxt = '0;
            next_issue_nxt = 32'(ws);
            end_chunk_nxt  = cwr_pkg::FREE_MARK;
            sent_total_nxt = '0;
            recv_total_nxt = '0;
            active_nxt     = 1'b1;
          end else if (active_r &&
                       cwr_pkg::cmd_t'(in_ch.command) == cwr_pkg::CMD_TICK) begin
            state_nxt = cwr_pkg::S_TICK_SCAN;
          end else if (active_r &&
                       cwr_pkg::cmd_t'(in_ch.command) == cwr_pkg::CMD_RESPONSE) begin
            recv_total_nxt = recv_total_r + 32'd1;
            if (!in_ch.frame_ok) begin
              kind_nxt  = cwr_pkg::K_REJECTED;
              state_nxt = cwr_pkg::S_STATUS;
            end else if (!in_ch.reply_ok) begin
              active_nxt = 1'b0;
              kind_nxt   = cwr_pkg::K_FAILED;
              state_nxt  = cwr_pkg::S_STATUS;
            end else begin
              state_nxt = cwr_pkg::S_FIND;
            end
          end
        end
      end

      // Walk slots, issue requests for new or stale chunks
      cwr_pkg::S_TICK_SCAN: begin
        if (at_end) begin
          state_nxt = cwr_pkg::S_FLUSH;
        end else if (slot_chunk_r[cur] != cwr_pkg::FREE_MARK &&
                     (!slot_req_r[cur] ||
                      (!slot_rcv_r[cur] &&
                       (now_r - slot_sent_r[cur]) > resend_period_r))) begin
          slot_req_nxt[cur]  = 1'b1;
          slot_sent_nxt[cur] = now_r;
          sent_total_nxt     = sent_total_r + 32'd1;
          op_chunk_nxt       = slot_chunk_r[cur];
          op_cnt_nxt         = slot_exp_r[cur];
          op_mul_nxt         = slot_exp_r[cur];
          kind_nxt           = cwr_pkg::K_REQUEST;
          ret_nxt            = cwr_pkg::S_TICK_SCAN;
          idx_nxt            = idx_r + 1'b1;
          state_nxt          = cwr_pkg::S_EMIT_MUL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Emit a request or write with chunk times length as offset
      cwr_pkg::S_EMIT_MUL: begin
        if (can_push) begin
          push                   = 1'b1;
          any_nxt                = 1'b1;
          push_res.kind          = kind_r;
          push_res.chunk_index   = op_chunk_r;
          push_res.byte_count    = op_cnt_r;
          push_res.byte_offset   = {16'd0, product};
          push_res.requests_sent = sent_total_r;
          push_res.replies_seen  = recv_total_r;
          state_nxt              = ret_r;
        end
      end

      // Find the slot holding the response's chunk
      cwr_pkg::S_FIND: begin
        if (at_end || rindex_r == cwr_pkg::FREE_MARK) begin
          kind_nxt  = cwr_pkg::K_REJECTED;
          state_nxt = cwr_pkg::S_STATUS;
        end else if (slot_chunk_r[cur] == rindex_r) begin
          state_nxt = cwr_pkg::S_CHECK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Check length, store the reply
      cwr_pkg::S_CHECK: begin
        if (!rend_r && rlen_r != slot_exp_r[cur]) begin
          kind_nxt  = cwr_pkg::K_REJECTED;
          state_nxt = cwr_pkg::S_STATUS;
        end else begin
          slot_rcv_nxt[cur]  = 1'b1;
          slot_rlen_nxt[cur] = rlen_r;
          if (rend_r) begin
            next_issue_nxt = '0;
            end_chunk_nxt  = rindex_r;
          end
          idx_nxt   = '0;
          k_nxt     = '0;
          state_nxt = cwr_pkg::S_DRAIN_FIND;
        end
      end

      // Find the slot of the next chunk to write
      cwr_pkg::S_DRAIN_FIND: begin
        if (at_end || next_write_r == cwr_pkg::FREE_MARK) begin
          state_nxt = cwr_pkg::S_POST;
        end else if (slot_chunk_r[cur] == next_write_r) begin
          state_nxt = slot_rcv_r[cur] ? cwr_pkg::S_DRAIN_ACT : cwr_pkg::S_POST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Write a received chunk, or fail on an empty one before the end
      cwr_pkg::S_DRAIN_ACT: begin
        if (slot_rlen_r[cur] != 16'd0) begin
          op_chunk_nxt = slot_chunk_r[cur];
          op_cnt_nxt   = slot_rlen_r[cur];
          op_mul_nxt   = slot_exp_r[cur];
          kind_nxt     = cwr_pkg::K_WRITE;
          ret_nxt      = cwr_pkg::S_DRAIN_REFILL;
          state_nxt    = cwr_pkg::S_EMIT_MUL;
        end else if (next_issue_r != '0) begin
          active_nxt = 1'b0;
          kind_nxt   = cwr_pkg::K_FAILED;
          state_nxt  = cwr_pkg::S_STATUS;
        end else begin
          state_nxt = cwr_pkg::S_DRAIN_REFILL;
        end
      end

      // Refill the freed slot and advance
      cwr_pkg::S_DRAIN_REFILL: begin
        slot_chunk_nxt[cur] = (next_issue_r != '0) ? next_issue_r : cwr_pkg::FREE_MARK;
        slot_req_nxt[cur]   = 1'b0;
        slot_sent_nxt[cur]  = '0;
        slot_exp_nxt[cur]   = eff_len;
        slot_rlen_nxt[cur]  = '0;
        slot_rcv_nxt[cur]   = 1'b0;
        if (next_issue_r != '0) begin
          next_issue_nxt = next_issue_r + 32'd1;
        end
        next_write_nxt = next_write_r + 32'd1;
        k_nxt          = k_r + 1'b1;
        idx_nxt        = '0;
        state_nxt      = (k_r + 1'b1 == ws) ? cwr_pkg::S_POST : cwr_pkg::S_DRAIN_FIND;
      end

      // Report accepted when nothing was released
      cwr_pkg::S_POST: begin
        if (any_r) begin
          idx_nxt   = '0;
          state_nxt = cwr_pkg::S_DONE_SCAN;
        end else if (can_push) begin
          push                   = 1'b1;
          any_nxt                = 1'b1;
          push_res.kind          = cwr_pkg::K_ACCEPTED;
          push_res.requests_sent = sent_total_r;
          push_res.replies_seen  = recv_total_r;
          idx_nxt                = '0;
          state_nxt              = cwr_pkg::S_DONE_SCAN;
        end
      end

      // Done when the end is known and no slot holds a chunk up to it
      cwr_pkg::S_DONE_SCAN: begin
        if (end_chunk_r == cwr_pkg::FREE_MARK) begin
          state_nxt = cwr_pkg::S_PAST_END;
        end else if (at_end) begin
          active_nxt = 1'b0;
          kind_nxt   = cwr_pkg::K_DONE;
          state_nxt  = cwr_pkg::S_STATUS;
        end else if (slot_chunk_r[cur] <= end_chunk_r) begin
          state_nxt = cwr_pkg::S_PAST_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      cwr_pkg::S_PAST_END: begin
        if (end_chunk_r != cwr_pkg::FREE_MARK && next_write_r > end_chunk_r) begin
          active_nxt = 1'b0;
          kind_nxt   = cwr_pkg::K_FAILED;
          state_nxt  = cwr_pkg::S_STATUS;
        end else begin
          state_nxt = cwr_pkg::S_FLUSH;
        end
      end

      cwr_pkg::S_STATUS: begin
        if (can_push) begin
          push                   = 1'b1;
          any_nxt                = 1'b1;
          push_res.kind          = kind_r;
          push_res.requests_sent = sent_total_r;
          push_res.replies_seen  = recv_total_r;
          state_nxt              = cwr_pkg::S_FLUSH;
        end
      end

      // Release the held result marked as last of the run
      cwr_pkg::S_FLUSH: begin
        if (can_push) begin
          flush     = 1'b1;
          state_nxt = cwr_pkg::S_IDLE;
        end
      end

      default: state_nxt = cwr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < WINDOW; j++) begin
        slot_chunk_r[j] <= cwr_pkg::FREE_MARK;
        slot_req_r[j]   <= 1'b0;
        slot_sent_r[j]  <= '0;
        slot_exp_r[j]   <= rst_len;
        slot_rlen_r[j]  <= '0;
        slot_rcv_r[j]   <= 1'b0;
      end
      next_write_r <= '0;
      next_issue_r <= '0;
      end_chunk_r  <= cwr_pkg::FREE_MARK;
      sent_total_r <= '0;
      recv_total_r <= '0;
      active_r     <= 1'b0;
      state_r      <= cwr_pkg::S_IDLE;
      ret_r        <= cwr_pkg::S_IDLE;
      idx_r        <= '0;
      k_r          <= '0;
      kind_r       <= cwr_pkg::K_ACCEPTED;
      any_r        <= 1'b0;
    end else begin
      for (int j = 0; j < WINDOW; j++) begin
        slot_chunk_r[j] <= slot_chunk_nxt[j];
        slot_req_r[j]   <= slot_req_nxt[j];
        slot_sent_r[j]  <= slot_sent_nxt[j];
        slot_exp_r[j]   <= slot_exp_nxt[j];
        slot_rlen_r[j]  <= slot_rlen_nxt[j];
        slot_rcv_r[j]   <= slot_rcv_nxt[j];
      end
      next_write_r <= next_write_nxt;
      next_issue_r <= next_issue_nxt;
      end_chunk_r  <= end_chunk_nxt;
      sent_total_r <= sent_total_nxt;
      recv_total_r <= recv_total_nxt;
      active_r     <= active_nxt;
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      idx_r        <= idx_nxt;
      k_r          <= k_nxt;
      kind_r       <= kind_nxt;
      any_r        <= any_nxt;
    end
    now_r      <= now_nxt;
    rindex_r   <= rindex_nxt;
    rlen_r     <= rlen_nxt;
    rend_r     <= rend_nxt;
    op_chunk_r <= op_chunk_nxt;
    op_cnt_r   <= op_cnt_nxt;
    op_mul_r   <= op_mul_nxt;
  end

  cwr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .flush     (flush),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  assign out_ch.kind          = out_res.kind;
  assign out_ch.chunk_index   = out_res.chunk_index;
  assign out_ch.byte_count    = out_res.byte_count;
  assign out_ch.byte_offset   = out_res.byte_offset;
  assign out_ch.requests_sent = out_res.requests_sent;
  assign out_ch.replies_seen  = out_res.replies_seen;
  assign out_ch.last_of_run   = out_last;

endmodule

FILE: design/cwr_checker.sv
// ----------------------------------------------------------------------------
// cwr_checker: port-level checks
// Watches the request and result channels of the chunk window receiver.
// ----------------------------------------------------------------------------
module cwr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic       out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Status results other than accepted always close the run
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == cwr_pkg::K_REJECTED || out_kind == cwr_pkg::K_DONE ||
                  out_kind == cwr_pkg::K_FAILED)
    |-> out_last)
    else $error("rejected, done or failed not last of run");

  // A run still in progress blocks new requests
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken while a run is open");

  // Kind codes stay in range
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= cwr_pkg::K_FAILED)
    else $error("result kind out of range");

endmodule

bind chunk_window_receiver_top cwr_checker u_cwr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_last  (out_ch.last_of_run)
);
